// File: sv/nsfc_pkg.sv
// Shared constants, types and helper functions for the NMEA sentence framer/checker.
package nsfc_pkg;

    // Sentence length limit and the width of the position counter
    localparam int MAX_LEN = 128;
    localparam int POS_W   = $clog2(MAX_LEN);
    localparam int LEN_W   = 7;
    localparam int LEN_MAX = 127;

    // Sentence type codes
    localparam logic [1:0] KIND_GNRMC = 2'd0;
    localparam logic [1:0] KIND_GPGSA = 2'd1;
    localparam logic [1:0] KIND_GNGGA = 2'd2;

    // Special characters
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_STAR   = 8'h2A;

    // Type names, one row per type code, first character first
    localparam logic [7:0] KIND_NAMES [3][5] = '{
        '{8'h47, 8'h4E, 8'h52, 8'h4D, 8'h43},   // GNRMC
        '{8'h47, 8'h50, 8'h47, 8'h53, 8'h41},   // GPGSA
        '{8'h47, 8'h4E, 8'h47, 8'h47, 8'h41}    // GNGGA
    };

    // Output tdata: 26 bits of fields, padded to 32
    localparam int OUT_TDATA_W = 32;

    typedef struct packed {
        logic [LEN_W-1:0] sentence_length;
        logic [7:0]       received_sum;
        logic [7:0]       computed_sum;
        logic             checksum_ok;
        logic [1:0]       sentence_kind;
    } t_result;

    // Hex digit decode: valid flag and nibble value, either case
    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.valid = 1'b1;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.value = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.value = 4'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.value = 4'(c - 8'h57);
        end else begin
            h.valid = 1'b0;
        end
        return h;
    endfunction

    // Saturate a position to the reported length width
    function automatic logic [LEN_W-1:0] sat_len(input logic [POS_W-1:0] p);
        int v;
        v = int'(p);
        return (v > LEN_MAX) ? LEN_W'(LEN_MAX) : LEN_W'(v);
    endfunction

endpackage

// File: sv/nsfc_framer.sv
// Sentence state tracker: type match, running XOR, checksum digits, result build.
module nsfc_framer
    import nsfc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    output logic       o_res_valid,
    output t_result    o_res
);

    logic             r_in_sentence, n_in_sentence;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [2:0]       r_cand, n_cand;
    logic [7:0]       r_xor, n_xor;
    logic             r_star, n_star;
    logic [1:0]       r_cnt, n_cnt;
    logic             r_bad, n_bad;
    logic [7:0]       r_acc, n_acc;

    logic             start;
    logic             act;
    logic [POS_W-1:0] pos;
    logic [2:0]       cand;
    logic [7:0]       cur_xor;
    logic             star;
    logic [1:0]       cnt;
    logic             bad;
    logic [7:0]       acc;
    logic [2:0]       match;
    logic [2:0]       idx;
    logic             in_type;
    logic             drop;
    logic             is_cr;
    t_hex             hex;

    // Restart the sentence state on '$'
    always_comb begin
        start   = (i_byte == CH_DOLLAR);
        act     = start | r_in_sentence;
        pos     = start ? '0     : r_pos;
        cand    = start ? 3'b111 : r_cand;
        cur_xor = start ? 8'd0   : r_xor;
        star    = start ? 1'b0   : r_star;
        cnt     = start ? 2'd0   : r_cnt;
        bad     = start ? 1'b0   : r_bad;
        acc     = start ? 8'd0   : r_acc;
    end

    // Compare the byte against each type name at positions one to five
    always_comb begin
        in_type = (int'(pos) >= 1) && (int'(pos) <= 5);
        idx     = in_type ? 3'(int'(pos) - 1) : 3'd0;
        for (int k = 0; k < 3; k++) begin
            match[k] = !in_type || (KIND_NAMES[k][idx] == i_byte);
        end
    end

    // Next state and result
    always_comb begin
        n_in_sentence = r_in_sentence;
        n_pos         = r_pos;
        n_cand        = r_cand;
        n_xor         = r_xor;
        n_star        = r_star;
        n_cnt         = r_cnt;
        n_bad         = r_bad;
        n_acc         = r_acc;
        o_res_valid   = 1'b0;
        hex           = hex_decode(i_byte);
        is_cr         = (i_byte == CH_CR);
        drop          = 1'b0;

        o_res.sentence_kind   = cand[0] ? KIND_GNRMC : (cand[1] ? KIND_GPGSA : KIND_GNGGA);
        o_res.checksum_ok     = star && (cnt == 2'd2) && !bad && (acc == cur_xor);
        o_res.computed_sum    = cur_xor;
        o_res.received_sum    = star ? acc : 8'd0;
        o_res.sentence_length = sat_len(pos);

        if (i_step && act) begin
            n_in_sentence = 1'b1;
            n_pos         = pos;
            n_cand        = cand & match;
            n_xor         = cur_xor;
            n_star        = star;
            n_cnt         = cnt;
            n_bad         = bad;
            n_acc         = acc;

            // Drop on unknown type or on reaching the length limit
            if ((int'(pos) == 5) && ((cand & match) == 3'b000)) begin
                drop = 1'b1;
            end
            if (int'(pos) >= MAX_LEN - 1) begin
                drop = 1'b1;
            end

            if (drop) begin
                n_in_sentence = 1'b0;
            end else if (is_cr) begin
                n_in_sentence = 1'b0;
                o_res_valid   = (int'(pos) > 5);
            end else begin
                if (int'(pos) >= 1) begin
                    if (!star) begin
                        if (i_byte == CH_STAR) begin
                            n_star = 1'b1;
                        end else begin
                            n_xor = cur_xor ^ i_byte;
                        end
                    end else if (cnt < 2'd2) begin
                        if (!hex.valid) begin
                            n_bad = 1'b1;
                        end else begin
                            n_acc = {acc[3:0], hex.value};
                        end
                        n_cnt = cnt + 2'd1;
                    end else begin
                        n_bad = 1'b1;
                    end
                end
                n_pos = POS_W'(int'(pos) + 1);
            end
        end
    end

    // Hold the sentence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_sentence <= 1'b0;
            r_pos         <= '0;
            r_cand        <= 3'b111;
            r_xor         <= 8'd0;
            r_star        <= 1'b0;
            r_cnt         <= 2'd0;
            r_bad         <= 1'b0;
            r_acc         <= 8'd0;
        end else begin
            r_in_sentence <= n_in_sentence;
            r_pos         <= n_pos;
            r_cand        <= n_cand;
            r_xor         <= n_xor;
            r_star        <= n_star;
            r_cnt         <= n_cnt;
            r_bad         <= n_bad;
            r_acc         <= n_acc;
        end
    end

endmodule

// File: sv/nsfc_out_stage.sv
// Result register with stream handshake toward the consumer.
module nsfc_out_stage
    import nsfc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  t_result                i_res,
    input  logic                   i_m_tready,
    output logic                   o_free,
    output logic                   o_m_tvalid,
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);

    logic    r_valid, n_valid;
    t_result r_res;

    // Slot can take a new result when empty or being drained
    assign o_free = !r_valid || i_m_tready;

    always_comb begin
        n_valid = r_valid;
        if (i_m_tready) begin
            n_valid = 1'b0;
        end
        if (i_load) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Capture the result payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = OUT_TDATA_W'(r_res);

endmodule

// File: sv/nmea_sentence_framer_checker_top.sv
// Top level of the NMEA sentence framer and checksum checker.
//
//  channel | direction | tdata fields (lowest bit first)
//  s_axis  | in        | rx_byte[7:0]
//  m_axis  | out       | sentence_kind[1:0], checksum_ok[2], computed_sum[10:3],
//          |           | received_sum[18:11], sentence_length[25:19], zero[31:26]
//
// One byte per cycle unless a stalled result holds the input register; a byte
// waits in the input register and its result, if any, is loaded into the result
// register as the byte advances. Synchronous active-low reset clears the sentence
// state and both valid flags. Input stays open while the input register is empty
// or the result slot is empty or draining.
module nmea_sentence_framer_checker_top
    import nsfc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [7:0]             i_s_tdata,   // rx_byte[7:0]
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata    // kind, ok, computed, received, length
);

    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte;
    logic       out_free;
    logic       step;
    logic       res_valid;
    t_result    res;

    // Advance the held byte when the result slot can take its outcome
    assign step       = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || out_free;

    always_comb begin
        n_in_valid = r_in_valid;
        if (step) begin
            n_in_valid = 1'b0;
        end
        if (i_s_tvalid && o_s_tready) begin
            n_in_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    // Capture the incoming byte
    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_byte <= i_s_tdata;
        end
    end

    nsfc_framer u_framer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    nsfc_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (res_valid),
        .i_res      (res),
        .i_m_tready (i_m_tready),
        .o_free     (out_free),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata)
    );

`ifndef SYNTHESIS
    // A full input register that cannot advance blocks new input
    a_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_free) |-> !o_s_tready)
        else $error("input accepted while held byte is blocked");

    // Results are only produced when the byte actually advances
    a_res_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> step)
        else $error("result without a step");

    // Reported type is one of the three codes
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[1:0] != 2'b11))
        else $error("invalid sentence kind");

    // A reported sentence is longer than its type field
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[25:19] > 7'd5))
        else $error("result for a sentence shorter than its type");
`endif

endmodule

// File: bench/tb.sv
// Self-checking testbench for the NMEA sentence framer and checksum checker.
`timescale 1ns / 1ps

module tb;
    import nsfc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RES_W       = $bits(t_result);
    localparam int RANDOM_BYTES = 360;

    // Checksum tail shapes used by the random sentence generator
    typedef enum int {
        SUM_NONE,
        SUM_ONE_DIGIT,
        SUM_BAD_DIGIT,
        SUM_EXTRA_DIGIT,
        SUM_RANDOM,
        SUM_CORRECT
    } t_sum_style;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [7:0]             i_s_tdata;   // rx_byte[7:0]
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;   // kind, ok, computed, received, length

    // Sentence tracker state, mirrors the block's framing state
    bit         sent_open;
    int         sent_pos;
    logic [2:0] kind_alive;
    logic [7:0] body_xor;
    bit         star_hit;
    int         digit_cnt;
    bit         digit_bad;
    logic [7:0] digit_acc;

    t_result    pending_reports[$];
    t_result    seen_report;
    t_result    due_report;

    bit idle_on;
    int hold_request = 0;
    int hold_len;
    int stall_len;
    int bytes_sent;
    int random_bytes;
    int reports_seen;
    int good_sum_reports;
    int mismatches;
    int input_stalls;
    int cycle_count;

    nmea_sentence_framer_checker_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // 2 ns clock
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Nibble of a hex character; bit 4 set when it is not one
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
        if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 8'd10)};
        if (c >= "a" && c <= "f") return {1'b0, 4'(c - "a" + 8'd10)};
        return 5'h10;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
        logic [7:0] base;
        if (v < 4'd10) return 8'h30 + 8'(v);
        base = lower ? 8'h61 : 8'h41;
        return base + 8'(v) - 8'd10;
    endfunction

    function automatic logic [7:0] xor_of(input string s);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < s.len(); i++) acc ^= s[i];
        return acc;
    endfunction

    // Advance the sentence tracker by one accepted byte; queue a report on CR
    function automatic void track_sentence(input logic [7:0] b);
        t_result    r;
        logic [4:0] nib;
        int         p;
        if (b == CH_DOLLAR) begin
            sent_open  = 1'b1;
            sent_pos   = 0;
            kind_alive = 3'b111;
            body_xor   = 8'h00;
            star_hit   = 1'b0;
            digit_cnt  = 0;
            digit_bad  = 1'b0;
            digit_acc  = 8'h00;
        end
        if (!sent_open) return;
        p = sent_pos;

        // narrow the type candidates over the five type characters
        if (p >= 1 && p <= 5) begin
            for (int k = 0; k < 3; k++)
                if (KIND_NAMES[k][p-1] != b) kind_alive[k] = 1'b0;
            if (p == 5 && kind_alive == 3'b000) begin
                sent_open = 1'b0;
                return;
            end
        end

        // drop on reaching the length limit
        if (p >= MAX_LEN - 1) begin
            sent_open = 1'b0;
            return;
        end

        // end of sentence: report only once the type is known
        if (b == CH_CR) begin
            sent_open = 1'b0;
            if (p <= 5) return;
            r.sentence_kind   = kind_alive[0] ? KIND_GNRMC :
                                (kind_alive[1] ? KIND_GPGSA : KIND_GNGGA);
            r.checksum_ok     = star_hit && digit_cnt == 2 && !digit_bad &&
                                digit_acc == body_xor;
            r.computed_sum    = body_xor;
            r.received_sum    = star_hit ? digit_acc : 8'h00;
            r.sentence_length = (p > LEN_MAX) ? LEN_W'(LEN_MAX) : LEN_W'(p);
            pending_reports.push_back(r);
            return;
        end

        // body bytes feed the XOR until '*', then the two digits
        if (p >= 1) begin
            if (!star_hit) begin
                if (b == CH_STAR) star_hit = 1'b1;
                else body_xor ^= b;
            end else if (digit_cnt < 2) begin
                nib = nibble_of(b);
                if (nib[4]) digit_bad = 1'b1;
                else digit_acc = {digit_acc[3:0], nib[3:0]};
                digit_cnt++;
            end else begin
                digit_bad = 1'b1;
            end
        end
        sent_pos = p + 1;
    endfunction

    // Offer one byte after a random gap and hold it until the transaction completes
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = idle_on ? $urandom_range(0, 14) : 0;
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        do @(posedge i_clk); while (!o_s_tready);
        track_sentence(b);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // Send '$', body, optional correct checksum, then CR
    task automatic send_sentence(input string body, input bit with_sum, input bit lower);
        logic [7:0] sum;
        sum = xor_of(body);
        send_byte(CH_DOLLAR);
        send_text(body);
        if (with_sum) begin
            send_byte(CH_STAR);
            send_byte(hex_char(sum[7:4], lower));
            send_byte(hex_char(sum[3:0], lower));
        end
        send_byte(CH_CR);
    endtask

    function automatic logic [7:0] random_body_byte();
        logic [7:0] c;
        if ($urandom_range(0, 6) == 0) return 8'($urandom_range(0, 255));
        do c = 8'($urandom_range(8'h20, 8'h7E)); while (c == CH_DOLLAR || c == CH_STAR);
        return c;
    endfunction

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] c;
        logic [4:0] n;
        do begin
            c = 8'($urandom_range(0, 255));
            n = nibble_of(c);
        end while (!n[4] || c == CH_CR || c == CH_DOLLAR);
        return c;
    endfunction

    // Build one sentence with random type, body and checksum tail, then send it
    task automatic send_random_sentence(output int count);
        logic [7:0] line[$];
        logic [7:0] sum;
        logic [7:0] c;
        int         kind;
        int         body_len;
        int         keep;
        bit         lower;
        t_sum_style style;
        kind  = $urandom_range(0, 2);
        lower = $urandom_range(0, 1);
        line.push_back(CH_DOLLAR);
        for (int i = 0; i < 5; i++) line.push_back(KIND_NAMES[kind][i]);
        // corrupt one type character now and then
        if ($urandom_range(0, 9) == 0)
            line[$urandom_range(1, 5)] = 8'($urandom_range(8'h41, 8'h5A));
        // mostly short bodies, a few that run into the length limit
        body_len = ($urandom_range(0, 24) == 0) ? $urandom_range(108, 126)
                                                : $urandom_range(0, 20);
        repeat (body_len) line.push_back(random_body_byte());
        sum = 8'h00;
        for (int i = 1; i < line.size(); i++) sum ^= line[i];

        case ($urandom_range(0, 9))
            0:       style = SUM_NONE;
            1:       style = SUM_ONE_DIGIT;
            2:       style = SUM_BAD_DIGIT;
            3:       style = SUM_EXTRA_DIGIT;
            4:       style = SUM_RANDOM;
            default: style = SUM_CORRECT;
        endcase
        if (style != SUM_NONE) line.push_back(CH_STAR);
        case (style)
            SUM_ONE_DIGIT: line.push_back(hex_char(sum[7:4], lower));
            SUM_BAD_DIGIT: begin
                c = non_hex_byte();
                if ($urandom_range(0, 1)) begin
                    line.push_back(c);
                    line.push_back(hex_char(sum[3:0], lower));
                end else begin
                    line.push_back(hex_char(sum[7:4], lower));
                    line.push_back(c);
                end
            end
            SUM_EXTRA_DIGIT: begin
                line.push_back(hex_char(sum[7:4], lower));
                line.push_back(hex_char(sum[3:0], lower));
                line.push_back(hex_char(4'($urandom_range(0, 15)), lower));
            end
            SUM_RANDOM: begin
                line.push_back(hex_char(4'($urandom_range(0, 15)), lower));
                line.push_back(hex_char(4'($urandom_range(0, 15)), !lower));
            end
            SUM_CORRECT: begin
                line.push_back(hex_char(sum[7:4], lower));
                line.push_back(hex_char(sum[3:0], lower));
            end
            default: ;
        endcase

        // usually close with CR; sometimes leave open or cut before the type is known
        case ($urandom_range(0, 19))
            0: ;
            1: begin
                keep = $urandom_range(1, 6);
                while (line.size() > keep) void'(line.pop_back());
                line.push_back(CH_CR);
            end
            default: line.push_back(CH_CR);
        endcase

        foreach (line[i]) send_byte(line[i]);
        count = line.size();
    endtask

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Well-formed sentences of each type, field extremes, noise outside a sentence
    task automatic test_framing();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text("GNRMC*");
        send_byte(CH_CR);
        send_sentence("GNRMC", 1'b0, 1'b0);
        send_sentence("GPGSA,A,3,04,05", 1'b1, 1'b1);
        send_sentence("GNGGA,123519,4807.038,N", 1'b1, 1'b0);
        // body XOR cancels to zero
        send_sentence("GNRMCGNRMC", 1'b1, 1'b0);
        // body XOR reaches all ones
        send_text("$GNRMC");
        send_byte(8'hAA);
        send_text("*FF");
        send_byte(CH_CR);
        // raw extreme bytes in the body
        send_text("$GNGGA");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text("*00");
        send_byte(CH_CR);
    endtask

    // Unknown type, CR before the type is known, '$' restarting a sentence
    task automatic test_dropped();
        send_text("$GNRMX,1*00");
        send_byte(CH_CR);
        send_text("$GPG");
        send_byte(CH_CR);
        send_byte(CH_DOLLAR);
        send_byte(CH_CR);
        send_text("$GNR$GNGGA,1");
        send_byte(CH_CR);
        send_text("$GPGSA,9$GNRMC*");
        send_byte(CH_CR);
    endtask

    // Missing star, missing digits, bad digits, extra digit, wrong value
    task automatic test_checksum_digits();
        logic [7:0] sum;
        send_text("$GPGSA,1");
        send_byte(CH_CR);
        send_text("$GPGSA*");
        send_byte(CH_CR);
        send_text("$GPGSA*4");
        send_byte(CH_CR);
        send_text("$GPGSA*4G");
        send_byte(CH_CR);
        send_text("$GPGSA*g4");
        send_byte(CH_CR);
        send_text("$GNRMC*A*");
        send_byte(CH_CR);
        send_text("$GPGSA*00");
        send_byte(CH_CR);
        sum = xor_of("GPGSA");
        send_text("$GPGSA*");
        send_byte(hex_char(sum[7:4], 1'b0));
        send_byte(hex_char(sum[3:0], 1'b1));
        send_byte("7");
        send_byte(CH_CR);
    endtask

    // Longest sentence that still reports, then the ones that hit the limit
    task automatic test_length_limit();
        send_text("$GNRMC");
        repeat (120) send_byte("A");
        send_byte(CH_CR);
        send_text("$GNRMC");
        repeat (121) send_byte("A");
        send_byte(CH_CR);
        send_text("$GPGSA");
        repeat (140) send_byte("B");
        send_byte(CH_CR);
        send_sentence("GNGGA,after", 1'b1, 1'b0);
    endtask

    // Receiver holds off while short sentences arrive back to back
    task automatic test_backpressure();
        idle_on = 1'b0;
        hold_request <= 400;
        repeat (16) send_sentence("GPGSA,A,3", 1'b1, 1'b0);
        idle_on = 1'b1;
    endtask

    // Random traffic: mostly well-formed sentences, some noise in between
    task automatic test_random_stream();
        int n;
        while (random_bytes < RANDOM_BYTES) begin
            if ($urandom_range(0, 5) == 0) idle_on = !idle_on;
            send_random_sentence(n);
            random_bytes += n;
            repeat ($urandom_range(0, 3)) send_byte(random_body_byte());
        end
        idle_on = 1'b1;
    endtask

    // Result side: random stall per transaction, plus a long hold-off on request
    initial begin
        i_m_tready = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_request != 0) begin
                i_m_tready   <= 1'b0;
                hold_len      = hold_request;
                hold_request <= 0;
                repeat (hold_len) @(posedge i_clk);
            end
            stall_len = idle_on ? $urandom_range(0, 14) : 0;
            if (stall_len != 0) begin
                i_m_tready <= 1'b0;
                repeat (stall_len) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid && hold_request == 0);
        end
    end

    // Compare each result transaction with the oldest queued report
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            seen_report = t_result'(o_m_tdata[RES_W-1:0]);
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected report, expected none, got 0x%0h",
                         $time, o_m_tdata);
                mismatches++;
            end else begin
                due_report = pending_reports.pop_front();
                check_field("sentence_kind", due_report.sentence_kind,
                            seen_report.sentence_kind);
                check_field("checksum_ok", due_report.checksum_ok,
                            seen_report.checksum_ok);
                check_field("computed_sum", due_report.computed_sum,
                            seen_report.computed_sum);
                check_field("received_sum", due_report.received_sum,
                            seen_report.received_sum);
                check_field("sentence_length", due_report.sentence_length,
                            seen_report.sentence_length);
            end
            check_field("tdata padding", 0, int'(o_m_tdata[OUT_TDATA_W-1:RES_W]));
            if (seen_report.checksum_ok) good_sum_reports++;
            reports_seen++;
        end
    end

    // Watchdog and input stall count
    always @(posedge i_clk) begin
        cycle_count++;
        if (i_s_tvalid && !o_s_tready) input_stalls++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d reports outstanding", $time,
                     pending_reports.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = 8'h00;
        idle_on    = 1'b1;
        sent_open  = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_framing();
        test_dropped();
        test_checksum_digits();
        test_length_limit();
        test_backpressure();
        test_random_stream();

        // drain outstanding reports, then let the pipeline settle
        i_s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Covered %0d bytes: typed sentences, drops, checksum tails, length limit,",
                 bytes_sent);
        $display("random stream; %0d reports checked (%0d good checksum), %0d input stalls",
                 reports_seen, good_sum_reports, input_stalls);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
